@@ rtl/core/rsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rsfd_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rsfd_pkg;

  localparam int RECORDS       = 32;
  localparam int PAYLOAD_BYTES = 16;
  localparam int MAX_CAPACITY  = 32;
  localparam int HDR_BYTES     = 5;
  localparam int RESULT_LIMIT  = 32;

  localparam int REC_W     = $clog2(RECORDS);
  localparam int CNT_W     = $clog2(RECORDS + 1);
  localparam int PB_W      = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int PBC_W     = $clog2(PAYLOAD_BYTES + 1);
  localparam int PAY_DEPTH = RECORDS * (1 << PB_W);
  localparam int CAP_W     = 6;
  localparam int CAP_LIM   = (MAX_CAPACITY < RESULT_LIMIT) ? MAX_CAPACITY : RESULT_LIMIT;
  localparam int PCNT_W    = 5;
  localparam int J_W       = 6;

  localparam logic [7:0] PKT_TYPE_A = 8'd1;
  localparam logic [7:0] PKT_TYPE_B = 8'd3;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_REJECT = 2'd1,
    ST_BYTE   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef struct packed {
    logic parse_en;
    logic take_start;
    logic hdr_rd;
    logic walk_dec;
    logic rec_take;
    logic emit_hdr;
    logic pay_rd;
    logic emit_pay;
    logic finish;
    logic cmp_start;
    logic cmp_next;
    logic cmp_keep;
    logic cmp_step;
    logic cmp_end;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic walk_done;
    logic match;
    logic fits;
    logic last_hdr;
    logic len_zero;
    logic last_pay;
    logic any_taken;
    logic cmp_done;
    logic slot_taken;
    logic slot_inplace;
    logic copy_last;
  } sts_t;

endpackage

@@ rtl/core/rsfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsfd_ctrl
// Sequencer: packet intake, newest-first take walk, store compaction.
// ----------------------------------------------------------------------------
module rsfd_ctrl
  import rsfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_op_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRD, S_WHD, S_EHDR, S_PRD, S_PEMIT, S_FIN, S_CSCAN, S_CCOPY
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && sts_i.out_free) begin
          if (in_op_i) begin
            cmd_o.take_start = 1'b1;
            state_d = S_WRD;
          end else begin
            cmd_o.parse_en = 1'b1;
          end
        end
      end
      S_WRD: begin
        if (sts_i.walk_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.hdr_rd = 1'b1;
          state_d = S_WHD;
        end
      end
      S_WHD: begin
        if (sts_i.match && !sts_i.fits) begin
          state_d = S_FIN;
        end else if (sts_i.match) begin
          cmd_o.rec_take = 1'b1;
          state_d = S_EHDR;
        end else begin
          cmd_o.walk_dec = 1'b1;
          state_d = S_WRD;
        end
      end
      S_EHDR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_hdr = 1'b1;
          if (sts_i.last_hdr) begin
            if (sts_i.len_zero) begin
              cmd_o.walk_dec = 1'b1;
              state_d = S_WRD;
            end else begin
              state_d = S_PRD;
            end
          end
        end
      end
      S_PRD: begin
        cmd_o.pay_rd = 1'b1;
        state_d = S_PEMIT;
      end
      S_PEMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_pay = 1'b1;
          if (sts_i.last_pay) begin
            cmd_o.walk_dec = 1'b1;
            state_d = S_WRD;
          end else begin
            state_d = S_PRD;
          end
        end else begin
          // read data is not held; fetch the byte again
          state_d = S_PRD;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          if (sts_i.any_taken) begin
            cmd_o.cmp_start = 1'b1;
            state_d = S_CSCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CSCAN: begin
        if (sts_i.cmp_done) begin
          cmd_o.cmp_end = 1'b1;
          state_d = S_IDLE;
        end else if (sts_i.slot_taken) begin
          cmd_o.cmp_next = 1'b1;
        end else if (sts_i.slot_inplace) begin
          cmd_o.cmp_next = 1'b1;
          cmd_o.cmp_keep = 1'b1;
        end else begin
          state_d = S_CCOPY;
        end
      end
      S_CCOPY: begin
        cmd_o.cmp_step = 1'b1;
        if (sts_i.copy_last) begin
          cmd_o.cmp_next = 1'b1;
          cmd_o.cmp_keep = 1'b1;
          state_d = S_CSCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/rsfd_dp.sv @@
// ----------------------------------------------------------------------------
// rsfd_dp
// Datapath: packet parser, header/payload stores, take walk, output register.
// ----------------------------------------------------------------------------
module rsfd_dp
  import rsfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [7:0] in_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  input  logic [7:0] route_i,
  input  logic [7:0] select_mask_i,
  input  logic [7:0] select_value_i,
  input  logic [5:0] capacity_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [1:0] out_status_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  typedef enum logic [1:0] {PH_IDLE, PH_HDR, PH_PAY} phase_e;

  logic [39:0] hdr_mem [RECORDS];
  logic [7:0]  pay_mem [PAY_DEPTH];

  logic [CNT_W-1:0]  rc_q, rc_d;
  phase_e            phase_q, phase_d;
  logic              stop_q, stop_d, pv_q, pv_d;
  logic [39:0]       ph_q, ph_d;
  logic [PCNT_W-1:0] pcnt_q, pcnt_d;

  logic                  hwe, pwe;
  logic [REC_W-1:0]      hwaddr, hraddr;
  logic [39:0]           hwdata, hdr_rdata_q;
  logic [REC_W+PB_W-1:0] pwaddr, praddr;
  logic [7:0]            pwdata, pay_rdata_q;

  logic              res_v;
  status_e           res_st;

  logic [7:0]        route_q, mask_q, want_q;
  logic [CAP_W-1:0]  cap_q, used_q, size;
  logic [CNT_W-1:0]  wi_q, tcnt_q, ci_q, kept_q, last_slot;
  logic [REC_W-1:0]  widx_q;
  logic [39:0]       hreg_q;
  logic [J_W-1:0]    j_q, pidx;
  logic [RECORDS-1:0] taken_q;
  logic              hold_v_q;
  logic [7:0]        hold_b_q, emit_b;
  logic [PBC_W-1:0]  b_q, bm1;

  logic              ov_q;
  status_e           ost_q;
  logic [7:0]        ob_q;
  logic              ol_q;

  function automatic logic pv_q_next(input logic f, input logic nv, input logic ov);
    pv_q_next = f ? nv : ov;
  endfunction

  // parser
  always_comb begin
    logic stray, commit;
    stray   = 1'b0;
    commit  = 1'b0;
    rc_d    = rc_q;
    phase_d = phase_q;
    stop_d  = stop_q;
    pv_d    = pv_q;
    ph_d    = ph_q;
    pcnt_d  = pcnt_q;
    pwe     = 1'b0;
    res_v   = 1'b0;
    res_st  = ST_ACCEPT;
    if (cmd_i.parse_en) begin
      if (first_byte_i) begin
        pv_d    = (in_byte_i == PKT_TYPE_A) || (in_byte_i == PKT_TYPE_B);
        stop_d  = !pv_d;
        phase_d = PH_HDR;
        ph_d    = '0;
        pcnt_d  = '0;
      end else if (phase_q == PH_IDLE) begin
        stray = 1'b1;
      end else if (!stop_q) begin
        if (phase_q == PH_HDR) begin
          ph_d[{pcnt_q[2:0], 3'b000} +: 8] = in_byte_i;
          pcnt_d = pcnt_q + PCNT_W'(1);
          if (pcnt_q == PCNT_W'(1) && ph_d[15:0] == 16'd0) begin
            stop_d = 1'b1;
          end else if (pcnt_q == PCNT_W'(HDR_BYTES - 1)) begin
            if (in_byte_i > 8'(PAYLOAD_BYTES)) begin
              stop_d = 1'b1;
            end else if (in_byte_i == 8'd0) begin
              commit = 1'b1;
            end else begin
              phase_d = PH_PAY;
              pcnt_d  = '0;
            end
          end
        end else begin
          pwe    = (rc_q < CNT_W'(RECORDS));
          pcnt_d = pcnt_q + PCNT_W'(1);
          if (({3'b000, pcnt_q} + 8'd1) >= ph_q[39:32]) commit = 1'b1;
        end
      end
      if (commit) begin
        if (rc_q < CNT_W'(RECORDS)) rc_d = rc_q + CNT_W'(1);
        phase_d = PH_HDR;
        pcnt_d  = '0;
      end
      if (last_byte_i && !stray) begin
        res_v   = 1'b1;
        res_st  = pv_q_next(first_byte_i, pv_d, pv_q) ? ST_ACCEPT : ST_REJECT;
        phase_d = PH_IDLE;
        stop_d  = 1'b0;
        pcnt_d  = '0;
      end
    end
    if (cmd_i.cmp_end) rc_d = rc_q - tcnt_q;
    hwe    = cmd_i.parse_en && commit && (rc_q < CNT_W'(RECORDS));
    hwaddr = rc_q[REC_W-1:0];
    hwdata = ph_d;
    if (commit || (cmd_i.parse_en && last_byte_i && !stray)) ph_d = '0;
    pwaddr = {rc_q[REC_W-1:0], pcnt_q[PB_W-1:0]};
    pwdata = in_byte_i;
    if (cmd_i.cmp_step && b_q == PBC_W'(1)) begin
      hwe    = 1'b1;
      hwaddr = kept_q[REC_W-1:0];
      hwdata = hdr_rdata_q;
    end
    if (cmd_i.cmp_step && b_q != '0) begin
      pwe    = 1'b1;
      pwaddr = {kept_q[REC_W-1:0], bm1[PB_W-1:0]};
      pwdata = pay_rdata_q;
    end
  end

  assign bm1    = b_q - PBC_W'(1);
  assign pidx   = j_q - J_W'(HDR_BYTES);
  assign hraddr = cmd_i.hdr_rd ? REC_W'(wi_q - CNT_W'(1)) : ci_q[REC_W-1:0];
  assign praddr = cmd_i.pay_rd ? {widx_q, pidx[PB_W-1:0]}
                               : {ci_q[REC_W-1:0], b_q[PB_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (hwe) hdr_mem[hwaddr] <= hwdata;
    hdr_rdata_q <= hdr_mem[hraddr];
  end

  always_ff @(posedge clk_i) begin
    if (pwe) pay_mem[pwaddr] <= pwdata;
    pay_rdata_q <= pay_mem[praddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q    <= '0;
      phase_q <= PH_IDLE;
      stop_q  <= 1'b0;
      pv_q    <= 1'b0;
      ph_q    <= '0;
      pcnt_q  <= '0;
    end else begin
      rc_q    <= rc_d;
      phase_q <= phase_d;
      stop_q  <= stop_d;
      pv_q    <= pv_d;
      ph_q    <= ph_d;
      pcnt_q  <= pcnt_d;
    end
  end

  // take walk status
  assign size = CAP_W'(HDR_BYTES) + hdr_rdata_q[37:32];
  assign last_slot = (rc_q == CNT_W'(RECORDS)) ? CNT_W'(RECORDS - 1) : rc_q;
  assign emit_b = cmd_i.emit_hdr ? hreg_q[{j_q[2:0], 3'b000} +: 8] : pay_rdata_q;

  always_comb begin
    sts_o.out_free     = !ov_q || out_ready_i;
    sts_o.walk_done    = (wi_q == '0);
    sts_o.match        = (hdr_rdata_q[7:0] == route_q) &&
                         ((hdr_rdata_q[15:8] & mask_q) == want_q);
    sts_o.fits         = (size <= (cap_q - used_q));
    sts_o.last_hdr     = (j_q == J_W'(HDR_BYTES - 1));
    sts_o.len_zero     = (hreg_q[39:32] == 8'd0);
    sts_o.last_pay     = (j_q == (J_W'(HDR_BYTES - 1) + hreg_q[37:32]));
    sts_o.any_taken    = (tcnt_q != '0);
    sts_o.cmp_done     = (ci_q > last_slot);
    sts_o.slot_taken   = taken_q[ci_q[REC_W-1:0]];
    sts_o.slot_inplace = (kept_q == ci_q);
    sts_o.copy_last    = (b_q == PBC_W'(PAYLOAD_BYTES));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      taken_q  <= '0;
      tcnt_q   <= '0;
      wi_q     <= '0;
      used_q   <= '0;
      j_q      <= '0;
      ci_q     <= '0;
      kept_q   <= '0;
      b_q      <= '0;
    end else begin
      if (cmd_i.take_start) begin
        hold_v_q <= 1'b0;
        taken_q  <= '0;
        tcnt_q   <= '0;
        wi_q     <= rc_q;
        used_q   <= '0;
      end
      if (cmd_i.walk_dec) wi_q <= wi_q - CNT_W'(1);
      if (cmd_i.rec_take) begin
        taken_q[widx_q] <= 1'b1;
        tcnt_q <= tcnt_q + CNT_W'(1);
        used_q <= used_q + size;
        j_q    <= '0;
      end
      if (cmd_i.emit_hdr || cmd_i.emit_pay) begin
        hold_v_q <= 1'b1;
        j_q      <= j_q + J_W'(1);
      end
      if (cmd_i.finish) hold_v_q <= 1'b0;
      if (cmd_i.cmp_start) begin
        ci_q   <= '0;
        kept_q <= '0;
        b_q    <= '0;
      end
      if (cmd_i.cmp_next) ci_q <= ci_q + CNT_W'(1);
      if (cmd_i.cmp_keep) kept_q <= kept_q + CNT_W'(1);
      if (cmd_i.cmp_step) b_q <= sts_o.copy_last ? '0 : b_q + PBC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_start) begin
      route_q <= route_i;
      mask_q  <= select_mask_i;
      want_q  <= select_value_i;
      cap_q   <= (capacity_i > CAP_W'(CAP_LIM)) ? CAP_W'(CAP_LIM) : capacity_i;
    end
    if (cmd_i.hdr_rd) widx_q <= REC_W'(wi_q - CNT_W'(1));
    if (cmd_i.rec_take) hreg_q <= hdr_rdata_q;
    if (cmd_i.emit_hdr || cmd_i.emit_pay) hold_b_q <= emit_b;
  end

  // output word register; batch bytes lag one behind so the last can be marked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      if (res_v || cmd_i.finish || ((cmd_i.emit_hdr || cmd_i.emit_pay) && hold_v_q)) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_v) begin
      ost_q <= res_st;
      ob_q  <= 8'd0;
      ol_q  <= 1'b1;
    end else if (cmd_i.finish) begin
      ost_q <= hold_v_q ? ST_BYTE : ST_EMPTY;
      ob_q  <= hold_v_q ? hold_b_q : 8'd0;
      ol_q  <= 1'b1;
    end else if ((cmd_i.emit_hdr || cmd_i.emit_pay) && hold_v_q) begin
      ost_q <= ST_BYTE;
      ob_q  <= hold_b_q;
      ol_q  <= 1'b0;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_status_o = ost_q;
  assign out_byte_o   = ob_q;
  assign out_last_o   = ol_q;

endmodule

@@ rtl/core/record_store_filtered_drain_unit.sv @@
// ----------------------------------------------------------------------------
// record_store_filtered_drain_unit
// Packet record parser with a filtered, newest-first batch drain.
// ----------------------------------------------------------------------------
// Slave stream carries packet bytes (tuser[0]=0) or take requests (tuser[0]=1).
// A packet's last byte (tlast) returns one status word
// (accepted/rejected). Other packet bytes return nothing.
// A take request walks the store newest to oldest, reading each record header, and stops
// at the first match that does not fit; a match that fits emits its header bytes, then
// reads and emits each payload byte. If anything was taken, a compaction pass follows:
// each slot that stays in place or was taken is passed over; each slot that moves is copied.
// tready is low for the whole take.
// Result words wait in a one-word output register; the block keeps
// accepting bytes while it drains, but stalls when it is full and unread.
// Reset empties the store and closes any open packet; no clearing pass.
// ----------------------------------------------------------------------------
module record_store_filtered_drain_unit
  import rsfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // in_byte, route, select_mask, select_value, capacity
  input  logic [1:0]  s_axis_tuser,  // op, first_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic [1:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;

  rsfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser[0]),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  rsfd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_byte_i      (s_axis_tdata[7:0]),
    .first_byte_i   (s_axis_tuser[1]),
    .last_byte_i    (s_axis_tlast),
    .route_i        (s_axis_tdata[15:8]),
    .select_mask_i  (s_axis_tdata[23:16]),
    .select_value_i (s_axis_tdata[31:24]),
    .capacity_i     (s_axis_tdata[37:32]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_status_o   (m_axis_tuser),
    .out_byte_o     (m_axis_tdata),
    .out_last_o     (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input taken with no room for a result");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_BYTE) |-> m_axis_tlast)
    else $error("status word without last");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata == 8'd0))
    else $error("empty batch word carries data");
`endif

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for record_store_filtered_drain_unit: packet bytes and
// take requests are driven on the slave stream, and a local store model
// predicts each status and batch word, which is checked in order.
// ----------------------------------------------------------------------------
module tb
  import rsfd_pkg::*;
;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic       last;
  } word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  record_store_filtered_drain_unit u_top (.*);

  word_t      exp_words[$];
  int         errors;
  int         idle_cycles;

  // store model
  int         rec_cnt;
  logic [39:0] hdr_mem[RECORDS];
  logic [7:0] pay_mem[RECORDS][PAYLOAD_BYTES];
  int         phase;
  bit         stopped;
  logic [39:0] pend_hdr;
  int         pend_cnt;
  logic [7:0] pend_pay[PAYLOAD_BYTES];
  bit         pkt_ok;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_word(logic [1:0] st, logic [7:0] d, logic l);
    word_t w;
    w.status = st;
    w.data   = d;
    w.last   = l;
    exp_words.push_back(w);
  endfunction

  function automatic void commit_rec();
    int len;
    len = pend_hdr[39:32];
    if (rec_cnt < RECORDS) begin
      hdr_mem[rec_cnt] = pend_hdr;
      for (int j = 0; j < len; j++) pay_mem[rec_cnt][j] = pend_pay[j];
      rec_cnt++;
    end
    pend_hdr = '0;
    pend_cnt = 0;
    phase = 1;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    if (phase == 1) begin
      if (pend_cnt < HDR_BYTES) begin
        pend_hdr[8*pend_cnt +: 8] = b;
        pend_cnt++;
      end
      if (pend_cnt == 2 && pend_hdr[15:0] == 16'd0) begin
        stopped = 1;
        return;
      end
      if (pend_cnt == HDR_BYTES) begin
        if (b > PAYLOAD_BYTES) stopped = 1;
        else if (b == 0) commit_rec();
        else begin
          phase = 2;
          pend_cnt = 0;
        end
      end
    end else if (phase == 2) begin
      if (pend_cnt < PAYLOAD_BYTES) pend_pay[pend_cnt] = b;
      pend_cnt++;
      if (pend_cnt >= pend_hdr[39:32]) commit_rec();
    end
  endfunction

  function automatic void predict_take(logic [7:0] rt, logic [7:0] msk, logic [7:0] val,
                                       logic [5:0] cap_in);
    bit taken[RECORDS];
    bit full;
    int cap, used, sz, len, kept, n;
    cap = cap_in;
    if (cap > CAP_LIM) cap = CAP_LIM;
    full = 0;
    used = 0;
    n = 0;
    for (int i = 0; i < RECORDS; i++) taken[i] = 0;
    for (int i = rec_cnt - 1; i >= 0; i--) begin
      if (!full && hdr_mem[i][7:0] == rt && (hdr_mem[i][15:8] & msk) == val) begin
        len = hdr_mem[i][39:32];
        sz = HDR_BYTES + len;
        if (sz > cap - used) full = 1;
        else begin
          for (int j = 0; j < HDR_BYTES; j++) push_word(ST_BYTE, hdr_mem[i][8*j +: 8], 1'b0);
          for (int j = 0; j < len; j++) push_word(ST_BYTE, pay_mem[i][j], 1'b0);
          n += sz;
          used += sz;
          taken[i] = 1;
        end
      end
    end
    if (n == 0) begin
      push_word(ST_EMPTY, 8'd0, 1'b1);
      return;
    end
    exp_words[$].last = 1'b1;
    kept = 0;
    for (int i = 0; i < rec_cnt; i++) begin
      if (!taken[i]) begin
        hdr_mem[kept] = hdr_mem[i];
        pay_mem[kept] = pay_mem[i];
        kept++;
      end
    end
    rec_cnt = kept;
  endfunction

  function automatic void predict_byte(logic [7:0] b, bit first, bit last);
    if (first) begin
      pkt_ok = (b == PKT_TYPE_A || b == PKT_TYPE_B);
      stopped = !pkt_ok;
      phase = 1;
      pend_hdr = '0;
      pend_cnt = 0;
    end else if (phase == 0) begin
      return;
    end else if (!stopped) begin
      parse_byte(b);
    end
    if (last) begin
      push_word(pkt_ok ? ST_ACCEPT : ST_REJECT, 8'd0, 1'b1);
      phase = 0;
      stopped = 0;
      pend_hdr = '0;
      pend_cnt = 0;
    end
  endfunction

  task automatic send_word(bit op, logic [7:0] b, bit first, bit last,
                           logic [7:0] rt, logic [7:0] msk, logic [7:0] val,
                           logic [5:0] cap);
    int g;
    g = gap_len();
    @(negedge clk_i);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {8'h00, $urandom()};
      s_axis_tuser  <= 2'($urandom());
      s_axis_tlast  <= 1'($urandom());
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b0, cap, val, msk, rt, b};
    s_axis_tuser  <= {first, op};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op) predict_take(rt, msk, val, cap);
    else predict_byte(b, first, last);
  endtask

  task automatic send_byte(logic [7:0] b, bit first, bit last);
    send_word(1'b0, b, first, last, 8'($urandom()), 8'($urandom()), 8'($urandom()),
              6'($urandom()));
  endtask

  task automatic send_take(logic [7:0] rt, logic [7:0] msk, logic [7:0] val,
                           logic [5:0] cap);
    send_word(1'b1, 8'($urandom()), 1'($urandom()), 1'($urandom()), rt, msk, val, cap);
  endtask

  task automatic send_record(logic [7:0] t, logic [7:0] sel, logic [15:0] v, int len,
                             bit last_at_end);
    send_byte(t, 0, 0);
    send_byte(sel, 0, 0);
    send_byte(v[7:0], 0, 0);
    send_byte(v[15:8], 0, 0);
    send_byte(len[7:0], 0, last_at_end && len == 0);
    for (int j = 0; j < len; j++)
      send_byte(8'($urandom()), 0, last_at_end && j == len - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (exp_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_byte(8'hAA, 0, 1);
    send_byte(PKT_TYPE_A, 1, 0);
    send_record(8'h07, 8'hFF, 16'hFFFF, PAYLOAD_BYTES, 0);
    send_record(8'h07, 8'h00, 16'h0000, 0, 0);
    send_record(8'hFF, 8'h80, 16'h1234, 3, 1);
    send_byte(8'h05, 1, 0);
    send_record(8'h07, 8'h01, 16'h0, 1, 1);
    send_byte(PKT_TYPE_B, 1, 0);
    send_byte(8'h00, 0, 0);
    send_byte(8'h00, 0, 0);
    send_byte(8'h09, 0, 1);
    send_byte(PKT_TYPE_A, 1, 0);
    send_byte(8'h07, 0, 0);
    send_take(8'h07, 8'h00, 8'h00, 6'd63);
    send_byte(8'h01, 1, 0);
    send_byte(8'h07, 0, 0);
    send_byte(8'h02, 0, 0);
    send_byte(8'h0, 0, 0);
    send_byte(8'h0, 0, 0);
    send_byte(8'd200, 0, 1);
    send_take(8'hFF, 8'h80, 8'h80, 6'd0);
    send_take(8'hFF, 8'h80, 8'h80, 6'd8);
    send_take(8'h55, 8'h00, 8'h00, 6'd32);
  endtask

  task automatic test_full_store();
    send_byte(PKT_TYPE_B, 1, 0);
    for (int i = 0; i < RECORDS + 2; i++) send_record(8'h02, i[7:0], 16'h0, 0, 0);
    send_byte(8'h00, 0, 1);
    for (int i = 0; i < 8; i++) send_take(8'h02, 8'h00, 8'h00, 6'd32);
  endtask

  task automatic test_random(int n_items);
    int sent, r, len, nrec;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_byte($urandom_range(0, 3) != 0 ? 8'(PKT_TYPE_A + 2 * $urandom_range(0, 1))
                                            : 8'($urandom()), 1'b1, 1'b0);
        nrec = $urandom_range(1, 3);
        for (int i = 0; i < nrec; i++) begin
          len = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                          : $urandom_range(0, 4);
          send_record(8'($urandom_range(0, 3)), 8'($urandom()), 16'($urandom()),
                      len > PAYLOAD_BYTES ? 0 : len, i == nrec - 1);
          sent += 5 + (len > PAYLOAD_BYTES ? 0 : len);
        end
        if (len > PAYLOAD_BYTES) begin
          send_byte(len[7:0], 0, 1);
          sent++;
        end
      end else if (r < 85) begin
        send_take(8'($urandom_range(0, 3)), $urandom_range(0, 1) ? 8'h00 : 8'($urandom()),
                  $urandom_range(0, 1) ? 8'h00 : 8'($urandom()), 6'($urandom()));
        sent++;
      end else begin
        send_byte(8'($urandom()), 1'($urandom()), 1'($urandom()));
        sent++;
      end
      if (r == 99) wait_drained();
    end
  endtask

  initial begin
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 0;
    errors = 0;
    rec_cnt = 0;
    phase = 0;
    stopped = 0;
    pend_hdr = '0;
    pend_cnt = 0;
    pkt_ok = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    test_directed();
    test_full_store();
    wait_drained();
    test_random(260);
    wait_drained();
    repeat (50) @(negedge clk_i);
    if (errors == 0 && exp_words.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    m_axis_tready <= 0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 9) < 7) m_axis_tready <= 1;
      else begin
        m_axis_tready <= 0;
        repeat (gap_len()) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_words.size() == 0) begin
        $display("%0t unexpected word: status=%0d data=%02h last=%0b", $time,
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        w = exp_words.pop_front();
        if (w.status !== m_axis_tuser || w.data !== m_axis_tdata
            || w.last !== m_axis_tlast) begin
          $display("%0t mismatch: expected st=%0d d=%02h l=%0b, actual st=%0d d=%02h l=%0b",
                   $time, w.status, w.data, w.last, m_axis_tuser, m_axis_tdata,
                   m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
